### sv/assert_macros.svh
//------------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define CHK_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/pte_pkg.sv
//------------------------------------------------------------------------------
// pte_pkg
// Widths, constants and controller/datapath interface types of the tachometer.
//------------------------------------------------------------------------------
package pte_pkg;

    localparam int TICKS_PER_SECOND = 1000000;
    localparam int COEFF_FRAC_BITS  = 8;
    localparam int AVG_FRAC_BITS    = 4;

    localparam int COEFF_W   = 16;
    localparam int DEBOUNCE_W = 16;
    localparam int TIMEOUT_W = 32;
    localparam int DELTA_W   = 32;
    localparam int RPM_W     = 24;
    localparam int QUO_W     = RPM_W;

    // rpm numerator scale: 60 s/min * ticks/s in Q.AVG_FRAC_BITS
    localparam longint unsigned SPEED_SCALE =
        64'(60) * 64'(TICKS_PER_SECOND) * (64'(1) << AVG_FRAC_BITS);
    localparam int SCALE_W = $clog2(SPEED_SCALE + 1);
    localparam int PROD_W  = SCALE_W + COEFF_W;
    localparam int NUM_W   = PROD_W - COEFF_FRAC_BITS;
    localparam int CMP_W   = DELTA_W + QUO_W;
    localparam int CNT_W   = $clog2(QUO_W);

    localparam logic [SCALE_W-1:0]    SPEED_SCALE_V = SCALE_W'(SPEED_SCALE);
    localparam logic [RPM_W-1:0]      RPM_MAX       = '1;
    localparam logic [DELTA_W-1:0]    ELAPSED_MAX   = '1;
    localparam logic [CNT_W-1:0]      DIV_LAST      = CNT_W'(QUO_W - 1);

    localparam logic [COEFF_W-1:0]    COEFF_RESET    = 16'd256;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd1000;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 32'd2000000;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;
    localparam int CFG_DATA_W = 32;

    typedef struct packed {
        logic tick;
        logic mul;
        logic div_init;
        logic div_step;
        logic smooth;
        logic out_load;
    } pte_cmd_t;

    typedef struct packed {
        logic pulse;
    } pte_status_t;

endpackage

### sv/pulse_tachometer_ema.sv
//------------------------------------------------------------------------------
// pulse_tachometer_ema
// Period-measuring tachometer with debounce, quarter-weight smoothing and a
// no-pulse timeout.
//------------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per microsecond tick carrying the sampled pin.
//   m_ channel: one request per tick with the average rpm (Q20.4), the
//   availability flag and the pulse-accepted flag after that tick.
//   cfg_ channel: register writes (0 coeff, 1 debounce, 2 timeout), always
//   ready; write only while no tick is in flight.
// Sequencing:
//   a tick without an accepted pulse goes from its accept straight to the
//   hand-off; a tick with an accepted pulse runs multiply, divider setup,
//   24 one-bit divider steps in the serial divider, smoothing and hand-off.
//   s_ready is high only while the sequencer is idle, so a new tick is taken
//   only after the previous tick's result has been handed off.
// Reset: synchronous active-low aresetn restores the register defaults,
//   clears the average and availability and starts the timeout.
// Stall: a result waiting in the output register does not block the next
//   tick; that tick's result waits in the sequencer until m_ready frees it.
//------------------------------------------------------------------------------
module pulse_tachometer_ema
    import pte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_pin_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [RPM_W-1:0]      m_rpm_average,
    output logic                  m_rpm_available,
    output logic                  m_pulse_accepted,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pte_cmd_t    cmd;
    pte_status_t status;

    assign cfg_ready = 1'b1;

    pte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pte_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_pin_level      (s_pin_level),
        .cmd              (cmd),
        .status           (status),
        .m_rpm_average    (m_rpm_average),
        .m_rpm_available  (m_rpm_available),
        .m_pulse_accepted (m_pulse_accepted)
    );

endmodule

### sv/pte_datapath.sv
//------------------------------------------------------------------------------
// pte_datapath
// Tick state, configuration registers, speed multiplier, serial divider,
// exponential average and result payload registers.
//------------------------------------------------------------------------------
module pte_datapath
    import pte_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_pin_level,
    input  pte_cmd_t              cmd,
    output pte_status_t           status,
    output logic [RPM_W-1:0]      m_rpm_average,
    output logic                  m_rpm_available,
    output logic                  m_pulse_accepted
);

    logic [COEFF_W-1:0]    coeff_reg;
    logic [DEBOUNCE_W-1:0] debounce_ticks_reg;
    logic [TIMEOUT_W-1:0]  timeout_ticks_reg;

    logic                  last_pin_reg;
    logic [DEBOUNCE_W-1:0] db_count_reg, db_count_next;
    logic                  db_run_reg, db_run_next;
    logic [DELTA_W-1:0]    elapsed_reg, elapsed_next;
    logic [TIMEOUT_W-1:0]  to_count_reg, to_count_next;
    logic                  to_run_reg, to_run_next;
    logic [RPM_W-1:0]      avg_reg, avg_next;
    logic                  valid_reg, valid_next;
    logic                  accepted_reg;

    logic [DELTA_W-1:0]    delta_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  ovf_reg;
    logic [DELTA_W-1:0]    rem_reg;
    logic [QUO_W-1:0]      quo_reg;

    logic [DELTA_W-1:0]    el_inc;
    logic [TIMEOUT_W-1:0]  to_dec;
    logic [DEBOUNCE_W-1:0] db_dec;
    logic                  to_exp, db_exp, pulse, fall;
    logic [NUM_W-1:0]      num;
    logic [DELTA_W:0]      trial;
    logic [DELTA_W:0]      trial_diff;
    logic [RPM_W-1:0]      rpm;
    logic [RPM_W:0]        sum;

    // per-tick state update
    always_comb begin
        el_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        to_dec = (to_count_reg != '0) ? to_count_reg - 1'b1 : to_count_reg;
        db_dec = (db_count_reg != '0) ? db_count_reg - 1'b1 : db_count_reg;
        to_exp = to_run_reg && (to_dec == '0);
        db_exp = db_run_reg && (db_dec == '0);
        pulse  = db_exp && !s_pin_level;
        fall   = last_pin_reg && !s_pin_level;

        elapsed_next = pulse ? '0 : el_inc;

        if (pulse) begin
            to_count_next = timeout_ticks_reg;
        end else if (to_run_reg) begin
            to_count_next = to_dec;
        end else begin
            to_count_next = to_count_reg;
        end
        to_run_next = pulse ? 1'b1 : (to_exp ? 1'b0 : to_run_reg);

        avg_next   = to_exp ? '0 : avg_reg;
        valid_next = pulse ? 1'b1 : (to_exp ? 1'b0 : valid_reg);

        if (fall) begin
            db_count_next = debounce_ticks_reg;
        end else if (db_run_reg) begin
            db_count_next = db_dec;
        end else begin
            db_count_next = db_count_reg;
        end
        db_run_next = fall ? 1'b1 : (db_exp ? 1'b0 : db_run_reg);
    end

    assign status.pulse = pulse;

    // divider and smoothing arithmetic
    always_comb begin
        num        = prod_reg[PROD_W-1:COEFF_FRAC_BITS];
        trial      = {rem_reg, quo_reg[QUO_W-1]};
        trial_diff = trial - {1'b0, delta_reg};
        rpm        = ovf_reg ? RPM_MAX : quo_reg;
        sum        = {1'b0, avg_reg} - {3'b000, avg_reg[RPM_W-1:2]}
                   + {3'b000, rpm[RPM_W-1:2]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg          <= COEFF_RESET;
            debounce_ticks_reg <= DEBOUNCE_RESET;
            timeout_ticks_reg  <= TIMEOUT_RESET;
            last_pin_reg       <= 1'b1;
            db_count_reg       <= '0;
            db_run_reg         <= 1'b0;
            elapsed_reg        <= '0;
            to_count_reg       <= TIMEOUT_RESET;
            to_run_reg         <= 1'b1;
            avg_reg            <= '0;
            valid_reg          <= 1'b0;
            accepted_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_COEFF:    coeff_reg          <= cfg_data[COEFF_W-1:0];
                    CFG_DEBOUNCE: debounce_ticks_reg <= cfg_data[DEBOUNCE_W-1:0];
                    CFG_TIMEOUT:  timeout_ticks_reg  <= cfg_data[TIMEOUT_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.tick) begin
                last_pin_reg <= s_pin_level;
                db_count_reg <= db_count_next;
                db_run_reg   <= db_run_next;
                elapsed_reg  <= elapsed_next;
                to_count_reg <= to_count_next;
                to_run_reg   <= to_run_next;
                avg_reg      <= avg_next;
                valid_reg    <= valid_next;
                accepted_reg <= pulse;
            end else if (cmd.smooth) begin
                avg_reg <= sum[RPM_W] ? RPM_MAX : sum[RPM_W-1:0];
            end
        end
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        if (cmd.tick) begin
            delta_reg <= el_inc;
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(SPEED_SCALE_V) * PROD_W'(coeff_reg);
        end
        if (cmd.div_init) begin
            ovf_reg <= CMP_W'(num) >= {delta_reg, QUO_W'(0)};
            rem_reg <= DELTA_W'(num[NUM_W-1:QUO_W]);
            quo_reg <= num[QUO_W-1:0];
        end else if (cmd.div_step) begin
            if (!trial_diff[DELTA_W]) begin
                rem_reg <= trial_diff[DELTA_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[DELTA_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            m_rpm_average    <= avg_reg;
            m_rpm_available  <= valid_reg;
            m_pulse_accepted <= accepted_reg;
        end
    end

endmodule

### sv/pte_ctrl.sv
//------------------------------------------------------------------------------
// pte_ctrl
// Sequencer: accepts a tick, runs multiply, serial divide and smoothing on an
// accepted pulse, then hands the result to the output register.
//------------------------------------------------------------------------------
module pte_ctrl
    import pte_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  pte_status_t status,
    output pte_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MUL     = 3'd1;
    localparam logic [2:0] ST_DINIT   = 3'd2;
    localparam logic [2:0] ST_DIV     = 3'd3;
    localparam logic [2:0] ST_SMOOTH  = 3'd4;
    localparam logic [2:0] ST_PUBLISH = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.tick   = 1'b1;
                    state_next = status.pulse ? ST_MUL : ST_PUBLISH;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DINIT;
            end
            ST_DINIT: begin
                cmd.div_init = 1'b1;
                cnt_next     = DIV_LAST;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SMOOTH;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SMOOTH: begin
                cmd.smooth = 1'b1;
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH: begin
                if (slot_free) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### sv/pte_checker.sv
//------------------------------------------------------------------------------
// pte_checker
// Port-level checks of the tachometer, bound to the top level.
//------------------------------------------------------------------------------
`include "assert_macros.svh"

module pte_checker
    import pte_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [RPM_W-1:0] m_rpm_average,
    input logic             m_rpm_available,
    input logic             m_pulse_accepted
);

    `CHK_ASSERT(a_pulse_sets_available, aclk, aresetn, (m_valid && m_pulse_accepted) |-> m_rpm_available, "accepted pulse without availability")
    `CHK_ASSERT(a_unavailable_zero, aclk, aresetn, (m_valid && !m_rpm_available) |-> (m_rpm_average == '0), "nonzero average while unavailable")
    `CHK_ASSERT(a_one_tick_at_a_time, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "tick accepted while previous tick in flight")
    `CHK_ASSERT(a_result_holds, aclk, aresetn, (m_valid && !m_ready) |=> m_valid, "result dropped while stalled")
    `CHK_ASSERT_ALWAYS(a_reset_clears_output, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind pulse_tachometer_ema pte_checker u_pte_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_rpm_average    (m_rpm_average),
    .m_rpm_available  (m_rpm_available),
    .m_pulse_accepted (m_pulse_accepted)
);
